@@ rtl/jdp_pkg.sv @@
// Package for the bounded-distortion Jacobian projector.
// Holds widths, pipeline stage indexes, the stage payload type and helpers.
// No dependencies; every other file but jdp_if uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package jdp_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 20;
  localparam int DIR_BITS  = 30;

  // Root unit: 64-bit radicand, one root bit per stage.
  localparam int RAD_BITS  = 64;
  localparam int ROOT_BITS = 32;
  localparam int SQRT_LAT  = ROOT_BITS;

  // Divider: unsigned numerator and divisor, one quotient bit per stage.
  localparam int NUM_BITS = 63;
  localparam int DEN_BITS = 43;
  localparam int DIV_LAT  = NUM_BITS;

  // Divider lanes.
  localparam int NDIV   = 6;
  localparam int D_DIST = 0;
  localparam int D_T    = 1;
  localparam int D_CA   = 2;
  localparam int D_SA   = 3;
  localparam int D_CC   = 4;
  localparam int D_SD   = 5;

  // Pipeline stage indexes.
  localparam int S_IN     = 0;
  localparam int S_MUL    = 1;
  localparam int S_SQ     = 2;
  localparam int S_SUM    = 3;
  localparam int S_ROOT   = S_SUM + SQRT_LAT;
  localparam int S_SV     = S_ROOT + 1;
  localparam int S_DIVIN  = S_SV + 1;
  localparam int S_DIVOUT = S_DIVIN + DIV_LAT;
  localparam int S_QUO    = S_DIVOUT + 1;
  localparam int S_TK     = S_QUO + 1;
  localparam int S_CLAMP  = S_TK + 1;
  localparam int S_HG     = S_CLAMP + 1;
  localparam int S_SCALE  = S_HG + 1;
  localparam int S_OUT    = S_SCALE + 1;
  localparam int NST      = S_OUT + 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOWER  = 2'd0;
  localparam logic [1:0] CFG_UPPER  = 2'd1;
  localparam logic [1:0] CFG_DETTHR = 2'd2;

  localparam logic [30:0] WORD_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] k;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] kd;
    logic signed [63:0] kk;
    logic signed [63:0] sqa;
    logic signed [63:0] sqb;
    logic signed [63:0] sqc;
    logic signed [63:0] sqd;
    logic [63:0] xab;
    logic [63:0] xcd;
    logic degen;
    logic signed [31:0] degp00;
    logic [42:0] dent;
    logic [31:0] nab;
    logic [31:0] ncd;
    logic flip;
    logic [30:0] s0;
    logic signed [31:0] s1;
    logic signed [63:0] ks0;
    logic [NDIV-1:0][NUM_BITS-1:0] dnum;
    logic [NDIV-1:0][DEN_BITS-1:0] dden;
    logic [NDIV-1:0] dneg;
    logic [30:0] ratio;
    logic pk;
    logic signed [31:0] t;
    logic signed [31:0] ca;
    logic signed [31:0] sa;
    logic signed [31:0] cc;
    logic signed [31:0] sd;
    logic signed [63:0] tk;
    logic signed [31:0] n0;
    logic signed [31:0] n1;
    logic proj;
    logic signed [32:0] h;
    logic signed [32:0] g;
    logic signed [33:0] ra;
    logic signed [33:0] rb;
    logic signed [33:0] fc;
    logic signed [33:0] fd;
    logic signed [31:0] p00;
    logic signed [31:0] p01;
    logic signed [31:0] p10;
    logic signed [31:0] p11;
  } pipe_t;

  // Saturate a 64-bit signed value to the 32-bit word.
  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // Floor half of a sum and of a difference of two words.
  function automatic logic signed [31:0] half_sum(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) + 33'(y);
    return s[32:1];
  endfunction

  function automatic logic signed [31:0] half_dif(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) - 33'(y);
    return s[32:1];
  endfunction

  // Magnitude of a signed word as an unsigned word.
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Apply the sign back to an unsigned quotient.
  function automatic logic signed [63:0] signed_quo(input logic [NUM_BITS-1:0] q,
                                                    input logic neg);
    logic signed [63:0] v;
    v = $signed({1'b0, q});
    return neg ? -v : v;
  endfunction

  // Scale a direction fraction: round half up of h*u / 2^31.
  function automatic logic signed [33:0] scale_dir(input logic signed [32:0] h,
                                                   input logic signed [31:0] u);
    logic signed [64:0] pr;
    pr = 65'(h) * 65'(u);
    pr = (pr + (65'sd1 <<< DIR_BITS)) >>> (DIR_BITS + 1);
    return pr[33:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/jdp_if.sv @@
// Channel interfaces of the Jacobian projector: input item and result.
// Valid/ready handshake with the payload fields; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface jdp_item_if;
  logic valid;
  logic ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] face_bound;

  modport source (output valid, m00, m01, m10, m11, face_bound, input ready);
  modport sink (input valid, m00, m01, m10, m11, face_bound, output ready);
endinterface

interface jdp_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] p00;
  logic signed [31:0] p01;
  logic signed [31:0] p10;
  logic signed [31:0] p11;
  logic [30:0] distortion;
  logic [30:0] max_sv;
  logic signed [31:0] min_sv;
  logic flipped;
  logic degenerate;
  logic projected;

  modport source (output valid, p00, p01, p10, p11, distortion, max_sv, min_sv,
                  flipped, degenerate, projected, input ready);
  modport sink (input valid, p00, p01, p10, p11, distortion, max_sv, min_sv,
                flipped, degenerate, projected, output ready);
endinterface

`default_nettype wire

@@ rtl/jdp_isqrt.sv @@
// Pipelined floor square root, one root bit per register stage.
// Depends on jdp_pkg for the radicand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module jdp_isqrt (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [jdp_pkg::RAD_BITS-1:0]   radicand,
  output logic      [jdp_pkg::ROOT_BITS-1:0]  root
);

  logic [jdp_pkg::RAD_BITS-1:0]  rem_q  [jdp_pkg::ROOT_BITS];
  logic [jdp_pkg::ROOT_BITS-1:0] root_q [jdp_pkg::ROOT_BITS];

  for (genvar s = 0; s < jdp_pkg::ROOT_BITS; s++) begin : g_step
    localparam int B = jdp_pkg::ROOT_BITS - 1 - s;
    logic [jdp_pkg::RAD_BITS-1:0]  rem_in;
    logic [jdp_pkg::ROOT_BITS-1:0] root_in;
    logic [jdp_pkg::RAD_BITS:0]    trial;

    if (s == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // (root + 2^B)^2 - root^2, compared with what is left of the radicand.
    assign trial = ((jdp_pkg::RAD_BITS+1)'(root_in) << (B + 1))
                 + ((jdp_pkg::RAD_BITS+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[s]  <= jdp_pkg::RAD_BITS'({1'b0, rem_in} - trial);
          root_q[s] <= root_in | (jdp_pkg::ROOT_BITS'(1) << B);
        end else begin
          rem_q[s]  <= rem_in;
          root_q[s] <= root_in;
        end
      end
    end
  end

  assign root = root_q[jdp_pkg::ROOT_BITS-1];

endmodule

`default_nettype wire

@@ rtl/jdp_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Depends on jdp_pkg for the numerator and divisor widths.
`timescale 1ns / 1ps
`default_nettype none

module jdp_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [jdp_pkg::NUM_BITS-1:0]  num,
  input  wire logic [jdp_pkg::DEN_BITS-1:0]  den,
  output logic      [jdp_pkg::NUM_BITS-1:0]  quo
);

  logic [jdp_pkg::DEN_BITS-1:0] rem_q [jdp_pkg::NUM_BITS];
  logic [jdp_pkg::NUM_BITS-1:0] nq_q  [jdp_pkg::NUM_BITS];
  logic [jdp_pkg::DEN_BITS-1:0] den_q [jdp_pkg::NUM_BITS];

  for (genvar s = 0; s < jdp_pkg::NUM_BITS; s++) begin : g_step
    logic [jdp_pkg::DEN_BITS-1:0] rem_in;
    logic [jdp_pkg::NUM_BITS-1:0] nq_in;
    logic [jdp_pkg::DEN_BITS-1:0] den_in;
    logic [jdp_pkg::DEN_BITS:0]   trial;
    logic                         ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign den_in = den_q[s-1];
    end

    // Bring down the next numerator bit; the quotient bit shifts in below.
    assign trial = {rem_in, nq_in[jdp_pkg::NUM_BITS-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? jdp_pkg::DEN_BITS'(trial - {1'b0, den_in})
                       : trial[jdp_pkg::DEN_BITS-1:0];
        nq_q[s]  <= {nq_in[jdp_pkg::NUM_BITS-2:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo = nq_q[jdp_pkg::NUM_BITS-1];

endmodule

`default_nettype wire

@@ rtl/jacobian_distortion_projector.sv @@
// Throughput: one item per cycle; the pipeline stalls as a whole only while a
// result beat waits. Latency is set by the 32-stage root unit and the 63-stage
// dividers, which run one bit per stage. Reset (synchronous) clears the valid
// bits and sets the bounds to -1.0 and the determinant threshold to 2^-20.
// Depends on jdp_pkg, jdp_if, jdp_isqrt and jdp_div.
`timescale 1ns / 1ps
`default_nettype none

module jacobian_distortion_projector (
  input  wire logic          clk,
  input  wire logic          rst,
  jdp_item_if.sink           jacobian,
  jdp_result_if.source       result,
  input  wire logic          cfg_wen,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  localparam int NST = jdp_pkg::NST;

  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic [30:0]        det_threshold;

  jdp_pkg::pipe_t st  [NST];
  jdp_pkg::pipe_t nxt [NST];
  logic [NST-1:0] vld;
  logic           adv;

  logic [jdp_pkg::ROOT_BITS-1:0] root_ab, root_cd;
  logic [jdp_pkg::NUM_BITS-1:0]  quo [jdp_pkg::NDIV];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound   <= 32'shfff0_0000;
      upper_bound   <= 32'shfff0_0000;
      det_threshold <= 31'd1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        jdp_pkg::CFG_LOWER:  lower_bound   <= cfg_data;
        jdp_pkg::CFG_UPPER:  upper_bound   <= cfg_data;
        jdp_pkg::CFG_DETTHR: det_threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves unless the result beat is held.
  assign adv            = !vld[NST-1] || result.ready;
  assign jacobian.ready = adv;

  // Root units for the similarity and anti-similarity norms.
  jdp_isqrt u_sqrt_ab (.clk(clk), .en(adv), .radicand(st[jdp_pkg::S_SUM].xab),
                       .root(root_ab));
  jdp_isqrt u_sqrt_cd (.clk(clk), .en(adv), .radicand(st[jdp_pkg::S_SUM].xcd),
                       .root(root_cd));

  // Divider lanes: distortion, projection parameter and four direction fractions.
  for (genvar i = 0; i < jdp_pkg::NDIV; i++) begin : g_div
    jdp_div u_div (
      .clk (clk),
      .en  (adv),
      .num (st[jdp_pkg::S_DIVIN].dnum[i]),
      .den (st[jdp_pkg::S_DIVIN].dden[i]),
      .quo (quo[i])
    );
  end

  // Stage logic.
  always_comb begin
    logic signed [64:0] dif;
    logic signed [64:0] thr;
    logic [32:0]        sv_sum;
    logic signed [33:0] sv_dif;
    logic [30:0]        s0v;
    logic signed [31:0] s1v;
    logic [31:0]        s1abs;
    logic signed [63:0] tn;
    logic signed [63:0] qv;
    logic signed [31:0] n0v;
    logic signed [31:0] n1v;
    logic               pv;
    logic               over;
    jdp_pkg::pipe_t     sp;

    nxt[0] = st[0];
    for (int i = 1; i < NST; i++) begin
      nxt[i] = st[i-1];
    end

    // Input capture.
    nxt[jdp_pkg::S_IN].m00 = jacobian.m00;
    nxt[jdp_pkg::S_IN].m01 = jacobian.m01;
    nxt[jdp_pkg::S_IN].m10 = jacobian.m10;
    nxt[jdp_pkg::S_IN].m11 = jacobian.m11;
    nxt[jdp_pkg::S_IN].k   = jacobian.face_bound;

    // Similarity split and the determinant products.
    sp = st[jdp_pkg::S_IN];
    nxt[jdp_pkg::S_MUL].a  = jdp_pkg::half_sum(sp.m00, sp.m11);
    nxt[jdp_pkg::S_MUL].b  = jdp_pkg::half_dif(sp.m10, sp.m01);
    nxt[jdp_pkg::S_MUL].c  = jdp_pkg::half_dif(sp.m00, sp.m11);
    nxt[jdp_pkg::S_MUL].d  = jdp_pkg::half_sum(sp.m01, sp.m10);
    nxt[jdp_pkg::S_MUL].p1 = 64'(sp.m00) * 64'(sp.m11);
    nxt[jdp_pkg::S_MUL].p2 = 64'(sp.m01) * 64'(sp.m10);
    nxt[jdp_pkg::S_MUL].kd = 64'(sp.k) * 64'($signed({1'b0, det_threshold}));
    nxt[jdp_pkg::S_MUL].kk = 64'(sp.k) * 64'(sp.k);

    // Squares, degenerate test and the projection denominator.
    sp  = st[jdp_pkg::S_MUL];
    dif = 65'(sp.p1) - 65'(sp.p2);
    thr = $signed({14'b0, det_threshold, 20'b0});
    nxt[jdp_pkg::S_SQ].sqa    = 64'(sp.a) * 64'(sp.a);
    nxt[jdp_pkg::S_SQ].sqb    = 64'(sp.b) * 64'(sp.b);
    nxt[jdp_pkg::S_SQ].sqc    = 64'(sp.c) * 64'(sp.c);
    nxt[jdp_pkg::S_SQ].sqd    = 64'(sp.d) * 64'(sp.d);
    nxt[jdp_pkg::S_SQ].degen  = (dif > -thr) && (dif < thr);
    nxt[jdp_pkg::S_SQ].degp00 = jdp_pkg::sat64((sp.kd + 64'sd524288) >>> 20);
    nxt[jdp_pkg::S_SQ].dent   = 43'((sp.kk >>> 20) + 64'sd1048576);

    // Radicands for the two norms.
    sp = st[jdp_pkg::S_SQ];
    nxt[jdp_pkg::S_SUM].xab = sp.sqa + sp.sqb;
    nxt[jdp_pkg::S_SUM].xcd = sp.sqc + sp.sqd;

    // Singular values and orientation.
    sp     = st[jdp_pkg::S_ROOT];
    sv_sum = {1'b0, root_ab} + {1'b0, root_cd};
    s0v    = (sv_sum > 33'(jdp_pkg::WORD_MAX)) ? jdp_pkg::WORD_MAX : sv_sum[30:0];
    sv_dif = $signed({2'b0, root_ab}) - $signed({2'b0, root_cd});
    if (sv_dif > 34'sd2147483647) begin
      s1v = 32'sh7fff_ffff;
    end else if (sv_dif < -34'sd2147483647) begin
      s1v = -32'sh7fff_ffff;
    end else begin
      s1v = sv_dif[31:0];
    end
    nxt[jdp_pkg::S_SV].nab  = root_ab;
    nxt[jdp_pkg::S_SV].ncd  = root_cd;
    nxt[jdp_pkg::S_SV].flip = root_cd > root_ab;
    nxt[jdp_pkg::S_SV].s0   = s0v;
    nxt[jdp_pkg::S_SV].s1   = s1v;
    nxt[jdp_pkg::S_SV].ks0  = 64'(sp.k) * 64'($signed({1'b0, s0v}));

    // Divider operands as magnitude and sign.
    sp    = st[jdp_pkg::S_SV];
    s1abs = jdp_pkg::mag32(sp.s1);
    tn    = sp.ks0 + (64'(sp.s1) <<< jdp_pkg::FRAC_BITS);
    nxt[jdp_pkg::S_DIVIN].dnum[jdp_pkg::D_DIST] = 63'({sp.s0, 20'b0});
    nxt[jdp_pkg::S_DIVIN].dden[jdp_pkg::D_DIST] = 43'(s1abs);
    nxt[jdp_pkg::S_DIVIN].dneg[jdp_pkg::D_DIST] = 1'b0;
    nxt[jdp_pkg::S_DIVIN].dnum[jdp_pkg::D_T]    = tn[63] ? 63'(-tn) : tn[62:0];
    nxt[jdp_pkg::S_DIVIN].dden[jdp_pkg::D_T]    = sp.dent;
    nxt[jdp_pkg::S_DIVIN].dneg[jdp_pkg::D_T]    = tn[63];
    nxt[jdp_pkg::S_DIVIN].dnum[jdp_pkg::D_CA]   = 63'({jdp_pkg::mag32(sp.a), 30'b0});
    nxt[jdp_pkg::S_DIVIN].dden[jdp_pkg::D_CA]   = 43'(sp.nab);
    nxt[jdp_pkg::S_DIVIN].dneg[jdp_pkg::D_CA]   = sp.a[31];
    nxt[jdp_pkg::S_DIVIN].dnum[jdp_pkg::D_SA]   = 63'({jdp_pkg::mag32(sp.b), 30'b0});
    nxt[jdp_pkg::S_DIVIN].dden[jdp_pkg::D_SA]   = 43'(sp.nab);
    nxt[jdp_pkg::S_DIVIN].dneg[jdp_pkg::D_SA]   = sp.b[31];
    nxt[jdp_pkg::S_DIVIN].dnum[jdp_pkg::D_CC]   = 63'({jdp_pkg::mag32(sp.c), 30'b0});
    nxt[jdp_pkg::S_DIVIN].dden[jdp_pkg::D_CC]   = 43'(sp.ncd);
    nxt[jdp_pkg::S_DIVIN].dneg[jdp_pkg::D_CC]   = sp.c[31];
    nxt[jdp_pkg::S_DIVIN].dnum[jdp_pkg::D_SD]   = 63'({jdp_pkg::mag32(sp.d), 30'b0});
    nxt[jdp_pkg::S_DIVIN].dden[jdp_pkg::D_SD]   = 43'(sp.ncd);
    nxt[jdp_pkg::S_DIVIN].dneg[jdp_pkg::D_SD]   = sp.d[31];

    // Distortion, projection condition, t and the direction fractions.
    sp = st[jdp_pkg::S_DIVOUT];
    if (sp.s1 == 32'sd0) begin
      nxt[jdp_pkg::S_QUO].ratio = jdp_pkg::WORD_MAX;
      over = 1'b1;
    end else begin
      nxt[jdp_pkg::S_QUO].ratio = (quo[jdp_pkg::D_DIST] > 63'(jdp_pkg::WORD_MAX))
                                ? jdp_pkg::WORD_MAX : quo[jdp_pkg::D_DIST][30:0];
      over = $signed({1'b0, quo[jdp_pkg::D_DIST]}) > 64'(sp.k);
    end
    nxt[jdp_pkg::S_QUO].pk = (sp.k > 32'sd0) && (sp.flip || over);
    nxt[jdp_pkg::S_QUO].t  = jdp_pkg::sat64(
        jdp_pkg::signed_quo(quo[jdp_pkg::D_T], sp.dneg[jdp_pkg::D_T]));
    qv = jdp_pkg::signed_quo(quo[jdp_pkg::D_CA], sp.dneg[jdp_pkg::D_CA]);
    nxt[jdp_pkg::S_QUO].ca = (sp.nab == '0) ? 32'sh4000_0000 : qv[31:0];
    qv = jdp_pkg::signed_quo(quo[jdp_pkg::D_SA], sp.dneg[jdp_pkg::D_SA]);
    nxt[jdp_pkg::S_QUO].sa = (sp.nab == '0) ? 32'sd0 : qv[31:0];
    qv = jdp_pkg::signed_quo(quo[jdp_pkg::D_CC], sp.dneg[jdp_pkg::D_CC]);
    nxt[jdp_pkg::S_QUO].cc = (sp.ncd == '0) ? 32'sh4000_0000 : qv[31:0];
    qv = jdp_pkg::signed_quo(quo[jdp_pkg::D_SD], sp.dneg[jdp_pkg::D_SD]);
    nxt[jdp_pkg::S_QUO].sd = (sp.ncd == '0) ? 32'sd0 : qv[31:0];

    // Scale t by the bound.
    sp = st[jdp_pkg::S_QUO];
    nxt[jdp_pkg::S_TK].tk = 64'(sp.t) * 64'(sp.k);

    // New singular values, then the optional clamps.
    sp  = st[jdp_pkg::S_TK];
    n0v = sp.pk ? jdp_pkg::sat64((sp.tk + 64'sd524288) >>> 20) : $signed({1'b0, sp.s0});
    n1v = sp.pk ? sp.t : sp.s1;
    pv  = sp.pk;
    if ((lower_bound > 32'sd0) && (sp.s1 < lower_bound)) begin
      if (n0v < lower_bound) n0v = lower_bound;
      if (n1v < lower_bound) n1v = lower_bound;
      pv = 1'b1;
    end
    if ((upper_bound > 32'sd0) && ($signed({1'b0, sp.s0}) > upper_bound)) begin
      if (n0v > upper_bound) n0v = upper_bound;
      if (n1v > upper_bound) n1v = upper_bound;
      pv = 1'b1;
    end
    nxt[jdp_pkg::S_CLAMP].n0   = n0v;
    nxt[jdp_pkg::S_CLAMP].n1   = n1v;
    nxt[jdp_pkg::S_CLAMP].proj = pv;

    // Similarity and anti-similarity weights.
    sp = st[jdp_pkg::S_CLAMP];
    nxt[jdp_pkg::S_HG].h = 33'(sp.n0) + 33'(sp.n1);
    nxt[jdp_pkg::S_HG].g = 33'(sp.n0) - 33'(sp.n1);

    // Weighted direction products.
    sp = st[jdp_pkg::S_HG];
    nxt[jdp_pkg::S_SCALE].ra = jdp_pkg::scale_dir(sp.h, sp.ca);
    nxt[jdp_pkg::S_SCALE].rb = jdp_pkg::scale_dir(sp.h, sp.sa);
    nxt[jdp_pkg::S_SCALE].fc = jdp_pkg::scale_dir(sp.g, sp.cc);
    nxt[jdp_pkg::S_SCALE].fd = jdp_pkg::scale_dir(sp.g, sp.sd);

    // Rebuild and select the result.
    sp = st[jdp_pkg::S_SCALE];
    if (sp.degen) begin
      nxt[jdp_pkg::S_OUT].p00   = sp.degp00;
      nxt[jdp_pkg::S_OUT].p01   = 32'sd0;
      nxt[jdp_pkg::S_OUT].p10   = 32'sd0;
      nxt[jdp_pkg::S_OUT].p11   = $signed({1'b0, det_threshold});
      nxt[jdp_pkg::S_OUT].ratio = jdp_pkg::WORD_MAX;
      nxt[jdp_pkg::S_OUT].s0    = '0;
      nxt[jdp_pkg::S_OUT].s1    = 32'sd0;
      nxt[jdp_pkg::S_OUT].flip  = 1'b1;
      nxt[jdp_pkg::S_OUT].proj  = 1'b1;
    end else if (sp.proj) begin
      nxt[jdp_pkg::S_OUT].p00 = jdp_pkg::sat64(64'(sp.ra) + 64'(sp.fc));
      nxt[jdp_pkg::S_OUT].p01 = jdp_pkg::sat64(64'(sp.fd) - 64'(sp.rb));
      nxt[jdp_pkg::S_OUT].p10 = jdp_pkg::sat64(64'(sp.rb) + 64'(sp.fd));
      nxt[jdp_pkg::S_OUT].p11 = jdp_pkg::sat64(64'(sp.ra) - 64'(sp.fc));
    end else begin
      nxt[jdp_pkg::S_OUT].p00 = sp.m00;
      nxt[jdp_pkg::S_OUT].p01 = sp.m01;
      nxt[jdp_pkg::S_OUT].p10 = sp.m10;
      nxt[jdp_pkg::S_OUT].p11 = sp.m11;
    end
  end

  // Pipeline registers; valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], jacobian.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st <= nxt;
    end
  end

  // Result beat.
  assign result.valid      = vld[NST-1];
  assign result.p00        = st[NST-1].p00;
  assign result.p01        = st[NST-1].p01;
  assign result.p10        = st[NST-1].p10;
  assign result.p11        = st[NST-1].p11;
  assign result.distortion = st[NST-1].ratio;
  assign result.max_sv     = st[NST-1].s0;
  assign result.min_sv     = st[NST-1].s1;
  assign result.flipped    = st[NST-1].flip;
  assign result.degenerate = st[NST-1].degen;
  assign result.projected  = st[NST-1].proj;

`ifndef SYNTHESIS
  // A degenerate result carries the fixed flag and value pattern.
  a_degen_flags: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |->
      result.flipped && result.projected && result.max_sv == '0)
    else $error("degenerate result with wrong flags");

  // Outside the degenerate case the flip flag follows the sign of min_sv.
  a_flip_sign: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.degenerate |-> result.flipped == result.min_sv[31])
    else $error("flip flag disagrees with min_sv sign");

  // A held pipeline keeps its valid bits.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid bits moved during a stall");

  // An unprojected result is never degenerate.
  a_unproj: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.projected |-> !result.degenerate)
    else $error("unprojected degenerate result");
`endif

endmodule

`default_nettype wire
